FILE: rtl/dts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Delimiter token splitter package
// Shared types and constants for the streaming separator-based splitter.
// ----------------------------------------------------------------------------
package dts_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_SEP_LEN      = 2'd0;
  localparam logic [1:0] REG_SEP_BYTES    = 2'd1;
  localparam logic [1:0] REG_IGNORE_EMPTY = 2'd2;

  // Fixed field widths
  localparam int unsigned SepLenW   = 4;
  localparam int unsigned SepBytesW = 64;
  localparam int unsigned SepBytesN = SepBytesW / 8;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CLOSE,
    ST_FINISH
  } state_e;

  // One result item
  typedef struct packed {
    logic [7:0] token_byte;
    logic       has_byte;
    logic       token_end;
    logic       run_last;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/delimiter_token_splitter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: an item is taken in the idle state, then the scan state releases
// one byte or drops one matched separator per step and then decides to hold
// the rest, the close state closes the text and the finish state hands over
// the last result. A new item is taken only once the previous one is finished;
// a stalled result output stalls the scan.
// Reset: control state clears and the configuration registers take their reset values; payload registers are not reset.
// ----------------------------------------------------------------------------
// Delimiter token splitter core
// Cuts a byte stream into tokens at a configurable separator string, holding
// back bytes that may start a separator and releasing them when a match fails.
// ----------------------------------------------------------------------------
module delimiter_token_splitter_core #(
  parameter int unsigned MAX_SEP_LEN = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  // Input item channel
  input  wire logic        item_valid_i,
  output logic             item_ready_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        in_valid_i,
  input  wire logic        text_end_i,
  // Result channel
  output logic             res_valid_o,
  input  wire logic        res_ready_i,
  output logic [7:0]       token_byte_o,
  output logic             has_byte_o,
  output logic             token_end_o,
  output logic             run_last_o
);

  localparam int unsigned BufDepth = MAX_SEP_LEN + 1;
  localparam int unsigned CntW     = $clog2(BufDepth + 1);
  localparam int unsigned LenW     = $clog2(MAX_SEP_LEN + 1);

  // Configuration registers
  logic [dts_pkg::SepLenW-1:0]   sep_len_q;
  logic [dts_pkg::SepBytesW-1:0] sep_bytes_q;
  logic                          ign_q;

  // Sequencer and scan state
  dts_pkg::state_e  state_q, state_d;
  logic [7:0]       buf_q [BufDepth];
  logic [7:0]       buf_d [BufDepth];
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             end_q, end_d;
  logic             tok_ne_q, tok_ne_d;

  // Holding stage and output register
  dts_pkg::result_t pend_q, pend_d;
  logic             pend_vld_q, pend_vld_d;
  dts_pkg::result_t out_q, out_d;
  logic             out_vld_q, out_vld_d;

  // Step decode
  logic [7:0]       sep_arr [MAX_SEP_LEN];
  logic [LenW-1:0]  len_eff;
  logic             mism;
  logic             full_match;
  logic             part_hold;
  logic             mark_emit;
  logic             out_free;
  logic             can_push;
  logic             new_vld;
  dts_pkg::result_t new_res;

  assign cfg_ready_o  = 1'b1;
  assign item_ready_o = (state_q == dts_pkg::ST_IDLE);

  // Separator bytes beyond the register width read as zero.
  for (genvar g = 0; g < MAX_SEP_LEN; g++) begin : g_sep
    if (g < dts_pkg::SepBytesN) begin : g_byte
      assign sep_arr[g] = sep_bytes_q[8*g +: 8];
    end else begin : g_zero
      assign sep_arr[g] = 8'h00;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_len_q   <= dts_pkg::SepLenW'(1);
      sep_bytes_q <= dts_pkg::SepBytesW'(44);
      ign_q       <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dts_pkg::REG_SEP_LEN:      sep_len_q   <= cfg_data_i[dts_pkg::SepLenW-1:0];
        dts_pkg::REG_SEP_BYTES:    sep_bytes_q <= cfg_data_i;
        dts_pkg::REG_IGNORE_EMPTY: ign_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective separator length and the shared comparator bank against the
  // head of the candidate buffer.
  always_comb begin
    if (sep_len_q == '0) begin
      len_eff = LenW'(1);
    end else if (32'(sep_len_q) > MAX_SEP_LEN) begin
      len_eff = LenW'(MAX_SEP_LEN);
    end else begin
      len_eff = LenW'(sep_len_q);
    end
    mism = 1'b0;
    for (int i = 0; i < MAX_SEP_LEN; i++) begin
      if ((32'(i) < 32'(cnt_q)) && (32'(i) < 32'(len_eff)) &&
          (buf_q[i] != sep_arr[i])) begin
        mism = 1'b1;
      end
    end
    full_match = (32'(cnt_q) >= 32'(len_eff)) && !mism;
    part_hold  = (32'(cnt_q) < 32'(len_eff)) && !mism && !end_q;
    mark_emit  = !ign_q || tok_ne_q;
    out_free   = !out_vld_q || res_ready_i;
    can_push   = !pend_vld_q || out_free;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dts_pkg::ST_IDLE: begin
        if (item_valid_i) begin
          state_d = dts_pkg::ST_SCAN;
        end
      end
      dts_pkg::ST_SCAN: begin
        if (can_push && ((cnt_q == '0) || part_hold)) begin
          state_d = dts_pkg::ST_CLOSE;
        end
      end
      dts_pkg::ST_CLOSE: begin
        if (can_push) begin
          state_d = dts_pkg::ST_FINISH;
        end
      end
      dts_pkg::ST_FINISH: begin
        if (!pend_vld_q || out_free) begin
          state_d = dts_pkg::ST_IDLE;
        end
      end
      default: state_d = dts_pkg::ST_IDLE;
    endcase
  end

  // Datapath: buffer updates and result generation for each scan step.
  always_comb begin
    buf_d    = buf_q;
    cnt_d    = cnt_q;
    end_d    = end_q;
    tok_ne_d = tok_ne_q;
    new_vld  = 1'b0;
    new_res  = '0;
    case (state_q)
      dts_pkg::ST_IDLE: begin
        if (item_valid_i) begin
          end_d = text_end_i;
          if (in_valid_i) begin
            for (int i = 0; i < BufDepth; i++) begin
              if (cnt_q == CntW'(i)) begin
                buf_d[i] = in_byte_i;
              end
            end
            cnt_d = cnt_q + CntW'(1);
          end
        end
      end
      dts_pkg::ST_SCAN: begin
        if (can_push && (cnt_q != '0) && !part_hold) begin
          if (full_match) begin
            // Separator found: close the token and drop the separator.
            new_vld           = mark_emit;
            new_res.token_end = 1'b1;
            tok_ne_d          = 1'b0;
            for (int k = 1; k <= MAX_SEP_LEN; k++) begin
              if (len_eff == LenW'(k)) begin
                for (int i = 0; i < BufDepth - k; i++) begin
                  buf_d[i] = buf_q[i + k];
                end
              end
            end
            cnt_d = cnt_q - CntW'(len_eff);
          end else begin
            // Head byte cannot start a separator: release it.
            new_vld            = 1'b1;
            new_res.token_byte = buf_q[0];
            new_res.has_byte   = 1'b1;
            tok_ne_d           = 1'b1;
            for (int i = 0; i < BufDepth - 1; i++) begin
              buf_d[i] = buf_q[i + 1];
            end
            cnt_d = cnt_q - CntW'(1);
          end
        end
      end
      dts_pkg::ST_CLOSE: begin
        if (can_push && end_q) begin
          new_vld           = mark_emit;
          new_res.token_end = 1'b1;
          tok_ne_d          = 1'b0;
          cnt_d             = '0;
        end
      end
      default: ;
    endcase
  end

  // Holding stage: a result waits here until the next one or the end of the
  // item shows whether it is the last one of the item.
  always_comb begin
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !res_ready_i;
    if (new_vld) begin
      if (pend_vld_q) begin
        out_d          = pend_q;
        out_d.run_last = 1'b0;
        out_vld_d      = 1'b1;
      end
      pend_d     = new_res;
      pend_vld_d = 1'b1;
    end else if ((state_q == dts_pkg::ST_FINISH) && pend_vld_q && out_free) begin
      out_d          = pend_q;
      out_d.run_last = 1'b1;
      out_vld_d      = 1'b1;
      pend_vld_d     = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= dts_pkg::ST_IDLE;
      cnt_q      <= '0;
      end_q      <= 1'b0;
      tok_ne_q   <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      end_q      <= end_d;
      tok_ne_q   <= tok_ne_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    buf_q  <= buf_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign res_valid_o  = out_vld_q;
  assign token_byte_o = out_q.token_byte;
  assign has_byte_o   = out_q.has_byte;
  assign token_end_o  = out_q.token_end;
  assign run_last_o   = out_q.run_last;

endmodule
`default_nettype wire

FILE: rtl/dts_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Delimiter token splitter port checker
// Watches the top-level ports for result and sequencing rules.
// ----------------------------------------------------------------------------
module dts_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       item_valid_i,
  input wire logic       item_ready_o,
  input wire logic       res_valid_o,
  input wire logic       res_ready_i,
  input wire logic [7:0] token_byte_o,
  input wire logic       has_byte_o,
  input wire logic       token_end_o,
  input wire logic       run_last_o
);

  // A stalled result transfer keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(token_byte_o) &&
      $stable(has_byte_o) && $stable(token_end_o) && $stable(run_last_o))
    else $error("result changed while stalled");

  // A result is either a token byte or a bare end marker.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (has_byte_o != token_end_o))
    else $error("result is neither a byte nor a bare marker");

  // The block is busy in the cycle after it takes an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_i && item_ready_o |=> !item_ready_o)
    else $error("ready straight after an item transfer");

endmodule

bind delimiter_token_splitter_core dts_checker u_dts_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .item_valid_i (item_valid_i),
  .item_ready_o (item_ready_o),
  .res_valid_o  (res_valid_o),
  .res_ready_i  (res_ready_i),
  .token_byte_o (token_byte_o),
  .has_byte_o   (has_byte_o),
  .token_end_o  (token_end_o),
  .run_last_o   (run_last_o)
);
`default_nettype wire

FILE: verif/delimiter_token_splitter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimiter token splitter checker
// Watches the configuration, item and result channels of the splitter. It
// keeps its own copy of the separator settings and of the held bytes, works
// out the token stream that each accepted item should produce, and compares
// every result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module delimiter_token_splitter_checker #(
  parameter int unsigned MaxSepLen = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration write channel
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [63:0]       cfg_data_i,
  // Input item channel
  input  logic              item_valid_i,
  input  logic              item_ready_i,
  input  logic [7:0]        in_byte_i,
  input  logic              in_valid_i,
  input  logic              text_end_i,
  // Result channel
  input  logic              res_valid_i,
  input  logic              res_ready_i,
  input  logic [7:0]        token_byte_i,
  input  logic              has_byte_i,
  input  logic              token_end_i,
  input  logic              run_last_i,
  // Status towards the testbench top
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);

  // Shadow copy of the configuration registers.
  logic [3:0]       sep_len_q;
  logic [63:0]      sep_bytes_q;
  logic             ignore_empty_q;

  // Shadow copy of the match state.
  logic [7:0]       held_q [MaxSepLen];
  int unsigned      held_cnt;
  logic             token_open;

  // Token results still to be seen on the result channel, oldest first.
  dts_pkg::result_t token_q [$];
  int unsigned      fails    = 0;
  int unsigned      reported = 0;

  // Separator length as the block uses it: zero acts as one, and anything
  // above the maximum is clipped.
  function automatic int unsigned sep_width();
    int unsigned width;
    width = 32'(sep_len_q);
    if (width < 1) width = 1;
    if (width > MaxSepLen) width = MaxSepLen;
    return width;
  endfunction

  function automatic void push_token(logic [7:0] value, logic has, logic term);
    dts_pkg::result_t res;
    res.token_byte = value;
    res.has_byte   = has;
    res.token_end  = term;
    res.run_last   = 1'b0;
    token_q.insert(token_q.size(), res);
  endfunction

  // A bare marker closes the token, unless the token is empty and empty
  // tokens are suppressed.
  function automatic void close_token();
    if (!ignore_empty_q || token_open) push_token(8'h00, 1'b0, 1'b1);
    token_open = 1'b0;
  endfunction

  // Works out the results of one item: the held bytes plus the new byte are
  // scanned for the leftmost separator, bytes that cannot start one are
  // released, and a trailing separator prefix is held back.
  function automatic void predict_tokens(logic [7:0] value, logic has, logic is_end);
    logic [7:0]  cand [MaxSepLen+1];
    int unsigned n, pos, rem, width, k, first;
    logic        ok, done;
    n     = held_cnt;
    width = sep_width();
    first = token_q.size();
    for (k = 0; k < n; k++) cand[k] = held_q[k];
    if (has) begin
      cand[n] = value;
      n++;
    end
    pos  = 0;
    done = 1'b0;
    while (pos < n && !done) begin
      rem = n - pos;
      ok  = 1'b1;
      for (k = 0; k < width && k < rem; k++) begin
        if (cand[pos+k] != sep_bytes_q[8*k +: 8]) ok = 1'b0;
      end
      if (ok && rem >= width) begin
        close_token();
        pos += width;
      end else if (ok && !is_end) begin
        done = 1'b1;
      end else begin
        push_token(cand[pos], 1'b1, 1'b0);
        token_open = 1'b1;
        pos++;
      end
    end
    held_cnt = 0;
    while (pos < n && held_cnt < MaxSepLen) begin
      held_q[held_cnt] = cand[pos];
      held_cnt++;
      pos++;
    end
    if (is_end) begin
      close_token();
      held_cnt = 0;
    end
    if (token_q.size() > first) token_q[token_q.size()-1].run_last = 1'b1;
  endfunction

  // Transfers are taken in order: results first, as they always belong to
  // earlier items, then the item and the configuration write.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    dts_pkg::result_t got;
    dts_pkg::result_t want;
    if (!rst_ni) begin
      sep_len_q      = 4'd1;
      sep_bytes_q    = 64'd44;
      ignore_empty_q = 1'b0;
      held_cnt       = 0;
      token_open     = 1'b0;
      token_q.delete();
    end else begin
      if (res_valid_i && res_ready_i) begin
        got.token_byte = token_byte_i;
        got.has_byte   = has_byte_i;
        got.token_end  = token_end_i;
        got.run_last   = run_last_i;
        if (token_q.size() == 0) begin
          fails++;
          if (reported < 10) begin
            reported++;
            $display("%0t: unexpected result byte=%02h has=%0b end=%0b last=%0b", $realtime,
                     got.token_byte, got.has_byte, got.token_end, got.run_last);
          end
        end else begin
          want = token_q.pop_front();
          if (got.token_byte !== want.token_byte || got.has_byte !== want.has_byte ||
              got.token_end !== want.token_end || got.run_last !== want.run_last) begin
            fails++;
            if (reported < 10) begin
              reported++;
              $display("%0t: mismatch expected byte=%02h has=%0b end=%0b last=%0b", $realtime,
                       want.token_byte, want.has_byte, want.token_end, want.run_last);
              $display("%0t:          actual   byte=%02h has=%0b end=%0b last=%0b", $realtime,
                       got.token_byte, got.has_byte, got.token_end, got.run_last);
            end
          end
        end
      end
      if (item_valid_i && item_ready_i) predict_tokens(in_byte_i, in_valid_i, text_end_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          dts_pkg::REG_SEP_LEN:      sep_len_q      = cfg_data_i[3:0];
          dts_pkg::REG_SEP_BYTES:    sep_bytes_q    = cfg_data_i;
          dts_pkg::REG_IGNORE_EMPTY: ignore_empty_q = cfg_data_i[0];
          default: ;
        endcase
      end
    end
    fail_count_o <= fails;
    pending_o    <= token_q.size();
  end

endmodule

FILE: verif/delimiter_token_splitter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimiter token splitter testbench
// Drives texts through the splitter under several separator settings: a
// directed part for empty texts, empty items, partial matches, clipped
// separator lengths and a separator change in the middle of a text, then
// random texts built from separators, separator prefixes and noise. Bursty
// input, a patterned result stall and one long hold-off exercise the
// handshakes; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module delimiter_token_splitter_core_tb;

  localparam int unsigned MAX_SEP_LEN   = 8;
  localparam logic [1:0]  REG_SPARE     = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned PHASE_ITEMS   = 20;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        cfg_valid   = 1'b0;
  logic [1:0]  cfg_index   = '0;
  logic [63:0] cfg_data    = '0;
  logic        item_valid  = 1'b0;
  logic [7:0]  in_byte     = '0;
  logic        in_valid    = 1'b0;
  logic        text_end    = 1'b0;
  logic        res_ready   = 1'b0;
  logic        cfg_ready;
  logic        item_ready;
  logic        res_valid;
  logic [7:0]  token_byte;
  logic        has_byte;
  logic        token_end;
  logic        run_last;
  int unsigned fail_count;
  int unsigned pending;

  // Stimulus bookkeeping.
  logic [3:0]  cur_len     = 4'd1;
  logic [63:0] cur_sep     = 64'd44;
  int          burst_left  = 4;
  int unsigned item_total  = 0;
  int unsigned cycle_cnt   = 0;
  logic        hold_req    = 1'b0;
  logic        hold_done   = 1'b0;

  delimiter_token_splitter_core #(
    .MAX_SEP_LEN (MAX_SEP_LEN)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .in_byte_i    (in_byte),
    .in_valid_i   (in_valid),
    .text_end_i   (text_end),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .token_byte_o (token_byte),
    .has_byte_o   (has_byte),
    .token_end_o  (token_end),
    .run_last_o   (run_last)
  );

  delimiter_token_splitter_checker #(
    .MaxSepLen (MAX_SEP_LEN)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .item_valid_i (item_valid),
    .item_ready_i (item_ready),
    .in_byte_i    (in_byte),
    .in_valid_i   (in_valid),
    .text_end_i   (text_end),
    .res_valid_i  (res_valid),
    .res_ready_i  (res_ready),
    .token_byte_i (token_byte),
    .has_byte_i   (has_byte),
    .token_end_i  (token_end),
    .run_last_i   (run_last),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: stalls follow a randomly picked pattern, and once on request
  // the receiver holds off long enough for the block to back up.
  initial begin : result_sink
    logic [7:0] pattern;
    int         k;
    forever begin
      if (hold_req && !hold_done) begin
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      case ($urandom_range(0, 3))
        0:       pattern = 8'hFF;
        1:       pattern = 8'($urandom);
        2:       pattern = 8'h0F;
        default: pattern = 8'hB6;
      endcase
      for (k = 0; k < 16; k++) begin
        res_ready <= pattern[k % 8];
        @(posedge clk);
      end
    end
  end

  // Offers one item and returns at the edge of its transfer. Valid stays high
  // within a burst; at the end of a burst the sender pauses for a while.
  task automatic send_item(input logic [7:0] value, input logic has, input logic is_end);
    item_valid <= 1'b1;
    in_byte    <= value;
    in_valid   <= has;
    text_end   <= is_end;
    do @(posedge clk); while (!item_ready);
    if (has || is_end) item_total++;
    burst_left--;
    if (burst_left <= 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
  endtask

  task automatic send_str(input string text, input logic close);
    int i;
    for (i = 0; i < text.len(); i++) send_item(text[i], 1'b1, close && (i == text.len() - 1));
  endtask

  // Waits until every predicted result has been seen, then lets the block
  // finish any item that produced no result.
  task automatic wait_idle();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] index, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic [3:0] len, input logic [63:0] sep, input logic ignore,
                            input logic poke_spare);
    wait_idle();
    cfg_write(dts_pkg::REG_SEP_LEN, {60'd0, len});
    cfg_write(dts_pkg::REG_SEP_BYTES, sep);
    cfg_write(dts_pkg::REG_IGNORE_EMPTY, {63'd0, ignore});
    if (poke_spare) cfg_write(REG_SPARE, '1);
    cfg_valid <= 1'b0;
    cur_len = len;
    cur_sep = sep;
  endtask

  // Half the time a byte of the separator register, otherwise any byte.
  function automatic logic [7:0] rand_byte();
    if ($urandom_range(0, 1)) return cur_sep[8*$urandom_range(0, 7) +: 8];
    return 8'($urandom);
  endfunction

  // A random text made of whole separators, separator prefixes cut short,
  // loose bytes and the odd empty item, closed by an end transfer.
  task automatic send_random_text();
    int unsigned width, chunks, pick, cut, c, k;
    width  = (cur_len == 0) ? 1 : (32'(cur_len) > MAX_SEP_LEN) ? MAX_SEP_LEN : 32'(cur_len);
    chunks = $urandom_range(0, 6);
    for (c = 0; c < chunks; c++) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        for (k = 0; k < width; k++) send_item(cur_sep[8*k +: 8], 1'b1, 1'b0);
      end else if (pick < 5) begin
        cut = $urandom_range(0, width - 1);
        for (k = 0; k < cut; k++) send_item(cur_sep[8*k +: 8], 1'b1, 1'b0);
        send_item(rand_byte(), 1'b1, 1'b0);
      end else if (pick == 5) begin
        send_item(8'($urandom), 1'b0, 1'b0);
      end else begin
        send_item(rand_byte(), 1'b1, 1'b0);
      end
    end
    if ($urandom_range(0, 1)) send_item(8'($urandom), 1'b0, 1'b1);
    else send_item(rand_byte(), 1'b1, 1'b1);
  endtask

  initial begin : stimulus
    logic [3:0]  len_set [6];
    int unsigned phase, goal;
    logic [63:0] sep;
    len_set = '{4'd1, 4'd2, 4'd0, 4'd8, 4'd15, 4'd3};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: one-byte comma separator, empty tokens kept.
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b0);
    send_str("a,,b", 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h2C, 1'b1, 1'b1);

    // Three-byte separator with a failing partial match; empty tokens dropped.
    set_config(4'd3, 64'h0000_0000_0062_6161, 1'b1, 1'b1);
    send_str("aabaaab", 1'b0);
    send_item(8'h00, 1'b0, 1'b1);

    // Separator changed while bytes are held; a zero length acts as one.
    send_str("aa", 1'b0);
    set_config(4'd0, 64'hFFFF_FFFF_FFFF_FF61, 1'b0, 1'b0);
    send_item(8'h78, 1'b1, 1'b1);

    // Over-long length is clipped to the maximum; an all-zero separator.
    set_config(4'd15, 64'd0, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);

    // Random texts under a range of settings, extremes among them.
    for (phase = 0; phase < 6; phase++) begin
      if (phase == 3) sep = '1;
      else if (phase == 4) sep = '0;
      else sep = {$urandom, $urandom};
      set_config(len_set[phase], sep, phase[0], 1'b0);
      if (phase == 1) hold_req <= 1'b1;
      goal = item_total + PHASE_ITEMS;
      while (item_total < goal) send_random_text();
    end

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
